/* rtl/ieg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieg_pkg: shared types and constants of the input event generator
// Event kinds, per-lane flag bundle and fixed field widths.
// ----------------------------------------------------------------------------
package ieg_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned ENC_W   = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned VALUE_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHANGE     = 3'd0,
        KIND_RISE       = 3'd1,
        KIND_FALL       = 3'd2,
        KIND_LONG       = 3'd3,
        KIND_SWITCH     = 3'd4,
        KIND_ENC_CHANGE = 3'd5,
        KIND_INCREASE   = 3'd6,
        KIND_DECREASE   = 3'd7
    } t_kind;

    // what one input lane found for the sample being accepted
    typedef struct packed {
        logic change;   // input toggled
        logic rise;     // new level is high (rise, else fall)
        logic long_ev;  // hold time reached on an armed input
    } t_lane_flags;

endpackage
`default_nettype wire

/* rtl/input_event_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// input_event_generator: button edge, long-press, switch and encoder events
// Turns one sample beat (input word, encoder count, ms timestamp) into an
// ordered run of event beats, the final one marked with tlast.
// ----------------------------------------------------------------------------
// Usage: a sample beat is taken when the previous sample's events have all
// been moved into the output register (the final one may still be waiting
// on m_axis_tready). The merge stage picks one event per cycle while the
// output register can advance; a new sample waits until all are picked.
// A sample that causes no event produces no beat. Sixteen lanes test all
// input bits for edges and long presses in the accept cycle; the merge
// stage then sends per input bit (lowest first) change and rise/fall, then
// long press, then switch 0 and 1 changes, then encoder change (delta) and
// increase/decrease (new position). The user must write configuration only
// while no events are pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module input_event_generator #(
    parameter int unsigned NUM_INPUTS       = 16,
    parameter int unsigned SWITCH_POSITIONS = 3
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config: index 0 input_mask, index 1 long_press_ms
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    // sample stream
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,  // raw_inputs[15:0], encoder_position[47:16],
                                             // time_ms[79:48]
    // event stream
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output      logic [31:0]  m_axis_tdata,  // event_value[31:0]
    output      logic [2:0]   m_axis_tuser,  // event_kind[2:0]
    output      logic         m_axis_tlast   // last
);

    localparam logic CFG_MASK    = 1'b0;
    localparam logic CFG_LONG_MS = 1'b1;
    localparam int unsigned SW0_LSB = 9;
    localparam int unsigned SW1_LSB = 12;

    logic [ieg_pkg::WORD_W-1:0]  r_mask;
    logic [ieg_pkg::WORD_W-1:0]  r_long_ms;
    logic [1:0]                  r_sw [2];
    logic [ieg_pkg::ENC_W-1:0]   r_last_enc;

    logic                        load;
    logic [ieg_pkg::WORD_W-1:0]  word;
    logic [ieg_pkg::ENC_W-1:0]   enc;
    logic [ieg_pkg::TIME_W-1:0]  now;
    logic [ieg_pkg::WORD_W-1:0]  thresh;
    logic [ieg_pkg::ENC_W-1:0]   delta;
    logic [1:0]                  n_sw [2];
    logic [1:0]                  sw_change;
    logic                        idle;
    ieg_pkg::t_lane_flags        lane_flags [NUM_INPUTS];

    // position = SWITCH_POSITIONS - 1 - trailing zeros; empty or
    // out-of-range field keeps the old position
    function automatic logic [1:0] decode_switch(input logic [2:0] field,
                                                 input logic [1:0] old);
        logic [1:0] tz;
        logic [1:0] pos;
        tz  = field[0] ? 2'd0 : (field[1] ? 2'd1 : 2'd2);
        pos = old;
        if (field != 3'b000 && 32'(tz) < SWITCH_POSITIONS) begin
            pos = 2'(SWITCH_POSITIONS - 1) - tz;
        end
        return pos;
    endfunction

    assign word   = s_axis_tdata[15:0] & r_mask;
    assign enc    = s_axis_tdata[47:16];
    assign now    = s_axis_tdata[79:48];
    assign thresh = (r_long_ms == '0) ? ieg_pkg::WORD_W'(1) : r_long_ms;
    assign delta  = enc - r_last_enc;

    assign s_axis_tready = idle;
    assign load          = s_axis_tvalid && s_axis_tready;

    assign n_sw[0] = decode_switch(word[SW0_LSB +: 3], r_sw[0]);
    assign n_sw[1] = decode_switch(word[SW1_LSB +: 3], r_sw[1]);
    assign sw_change[0] = (n_sw[0] != r_sw[0]);
    assign sw_change[1] = (n_sw[1] != r_sw[1]);

    // one detector lane per input bit
    for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_lane
        ieg_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (load),
            .i_cur    (word[g]),
            .i_now    (now),
            .i_thresh (thresh),
            .o_flags  (lane_flags[g])
        );
    end

    ieg_merge #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_lane       (lane_flags),
        .i_sw_change  (sw_change),
        .i_enc_change (delta != '0),
        .i_enc_delta  (delta),
        .i_enc_pos    (enc),
        .o_idle       (idle),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_value      (m_axis_tdata),
        .o_kind       (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '1;
            r_long_ms  <= 16'd1000;
            r_sw[0]    <= '0;
            r_sw[1]    <= '0;
            r_last_enc <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MASK:    r_mask    <= i_cfg_data;
                    CFG_LONG_MS: r_long_ms <= i_cfg_data;
                    default:     r_mask    <= r_mask;
                endcase
            end
            if (load) begin
                r_sw[0]    <= n_sw[0];
                r_sw[1]    <= n_sw[1];
                r_last_enc <= enc;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/ieg_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieg_lane: edge and long-press detector for one input bit
// Holds the bit's previous level, rise timestamp and long-press arm flag.
// ----------------------------------------------------------------------------
module ieg_lane (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire logic                            i_cur,
    input  wire logic [ieg_pkg::TIME_W-1:0]      i_now,
    input  wire logic [ieg_pkg::WORD_W-1:0]      i_thresh,
    output      ieg_pkg::t_lane_flags            o_flags
);

    logic                         r_prev;
    logic                         r_armed;
    logic [ieg_pkg::TIME_W-1:0]   r_rise_time;
    logic                         n_armed;
    logic [ieg_pkg::TIME_W-1:0]   elapsed;
    logic                         change;
    logic                         long_ev;

    assign change  = i_cur ^ r_prev;
    assign elapsed = i_now - r_rise_time;
    // a rise in this sample is a change, so it never counts as a long press
    assign long_ev = i_cur && !change && r_armed &&
                     (elapsed >= ieg_pkg::TIME_W'(i_thresh));

    always_comb begin
        n_armed = r_armed;
        if (change) begin
            n_armed = i_cur;
        end
        if (long_ev) begin
            n_armed = 1'b0;
        end
    end

    assign o_flags = '{change: change, rise: i_cur, long_ev: long_ev};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_armed <= 1'b0;
        end else if (i_load) begin
            r_prev  <= i_cur;
            r_armed <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && change && i_cur) begin
            r_rise_time <= i_now;
        end
    end

endmodule
`default_nettype wire

/* rtl/ieg_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieg_merge: event merger and output register
// Collects lane, switch and encoder flags into an ordered pending set and
// sends the lowest pending event each cycle the output register can advance.
// ----------------------------------------------------------------------------
module ieg_merge #(
    parameter int unsigned NUM_INPUTS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire ieg_pkg::t_lane_flags              i_lane [NUM_INPUTS],
    input  wire logic [1:0]                        i_sw_change,
    input  wire logic                              i_enc_change,
    input  wire logic [ieg_pkg::VALUE_W-1:0]       i_enc_delta,
    input  wire logic [ieg_pkg::VALUE_W-1:0]       i_enc_pos,
    output      logic                              o_idle,
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      logic [ieg_pkg::VALUE_W-1:0]       o_value,
    output      logic [ieg_pkg::KIND_W-1:0]        o_kind,
    output      logic                              o_last
);

    // four slots per lane: change, rise/fall, long, unused;
    // the group after the last lane: switch 0, switch 1, enc change, enc dir
    localparam int unsigned W  = 4 * (NUM_INPUTS + 1);
    localparam int unsigned IW = $clog2(W);
    localparam int unsigned LW = IW - 2;

    logic [W-1:0]                r_pending;
    logic [W-1:0]                n_pending;
    logic [W-1:0]                built;
    logic [W-1:0]                low;
    logic [IW-1:0]               idx;
    logic [LW-1:0]               lane;
    logic [1:0]                  slot;
    logic [NUM_INPUTS:0]         r_rise;
    logic                        r_enc_dec;
    logic [ieg_pkg::VALUE_W-1:0] r_enc_delta;
    logic [ieg_pkg::VALUE_W-1:0] r_enc_pos;
    logic                        advance;
    logic                        pick;
    ieg_pkg::t_kind              kind;
    logic [ieg_pkg::VALUE_W-1:0] value;

    always_comb begin
        built = '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            built[4*i]     = i_lane[i].change;
            built[4*i + 1] = i_lane[i].change;
            built[4*i + 2] = i_lane[i].long_ev;
        end
        built[4*NUM_INPUTS]     = i_sw_change[0];
        built[4*NUM_INPUTS + 1] = i_sw_change[1];
        built[4*NUM_INPUTS + 2] = i_enc_change;
        built[4*NUM_INPUTS + 3] = i_enc_change;
    end

    // isolate lowest pending event, then encode its position
    assign low = r_pending & (~r_pending + W'(1));

    always_comb begin
        idx = '0;
        for (int j = 0; j < W; j++) begin
            if (low[j]) begin
                idx = idx | IW'(j);
            end
        end
    end

    assign lane = idx[IW-1:2];
    assign slot = idx[1:0];

    always_comb begin
        kind  = ieg_pkg::KIND_CHANGE;
        value = ieg_pkg::VALUE_W'(lane);
        if (lane < LW'(NUM_INPUTS)) begin
            case (slot)
                2'd0:    kind = ieg_pkg::KIND_CHANGE;
                2'd1:    kind = r_rise[lane] ? ieg_pkg::KIND_RISE : ieg_pkg::KIND_FALL;
                default: kind = ieg_pkg::KIND_LONG;
            endcase
        end else begin
            case (slot)
                2'd0: begin
                    kind  = ieg_pkg::KIND_SWITCH;
                    value = '0;
                end
                2'd1: begin
                    kind  = ieg_pkg::KIND_SWITCH;
                    value = ieg_pkg::VALUE_W'(1);
                end
                2'd2: begin
                    kind  = ieg_pkg::KIND_ENC_CHANGE;
                    value = r_enc_delta;
                end
                default: begin
                    kind  = r_enc_dec ? ieg_pkg::KIND_DECREASE : ieg_pkg::KIND_INCREASE;
                    value = r_enc_pos;
                end
            endcase
        end
    end

    assign advance = !o_valid || i_ready;
    assign pick    = advance && (r_pending != '0);
    assign o_idle  = (r_pending == '0);

    always_comb begin
        n_pending = r_pending;
        if (i_load) begin
            n_pending = built;
        end else if (pick) begin
            n_pending = r_pending & ~low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_pending <= n_pending;
            if (advance) begin
                o_valid <= (r_pending != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < NUM_INPUTS; i++) begin
                r_rise[i] <= i_lane[i].rise;
            end
            r_rise[NUM_INPUTS] <= 1'b0;
            r_enc_delta        <= i_enc_delta;
            r_enc_pos          <= i_enc_pos;
            r_enc_dec          <= i_enc_delta[ieg_pkg::VALUE_W-1];
        end
        if (pick) begin
            o_kind  <= kind;
            o_value <= value;
            o_last  <= ((r_pending & ~low) == '0);
        end
    end

    // new sample only lands on an empty pending set
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_pending == '0))
        else $error("sample loaded while events still pending");

    // a non-final beat on the output always has its successors pending
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_pending != '0))
        else $error("non-final beat with nothing left to send");

    // a picked event shows up on the output next cycle
    a_pick_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pick |=> o_valid)
        else $error("picked event not presented");

endmodule
`default_nettype wire

/* dv/ieg_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieg_event_checker: event predictor and beat comparator
// Watches the config port and both streams of the input event generator.
// Each accepted sample is turned into its expected event run. Each event
// beat is then compared with the oldest entry of that run.
// ----------------------------------------------------------------------------
package ieg_dv_pkg;

    // config register indexes
    localparam logic REG_INPUT_MASK = 1'b0;
    localparam logic REG_HOLD_MS    = 1'b1;

endpackage

module ieg_event_checker
    import ieg_pkg::*;
    import ieg_dv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [79:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    input  wire logic [2:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beat_count
);

    localparam int SW_POSITIONS = 3;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } t_event;

    // shadow of the block's registers and state
    logic [15:0] mask_q;
    logic [15:0] hold_q;
    logic [15:0] prev_word;
    logic [31:0] rise_at [16];
    logic [15:0] armed;
    logic [1:0]  sw_pos [2];
    logic [31:0] last_enc;

    t_event due_events [$];
    t_event run_buf [36];
    int     run_len;
    int     fails = 0;
    int     beats = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_beat_count = 0;
    end

    function automatic logic [1:0] switch_decode(input logic [2:0] field,
                                                 input logic [1:0] old);
        int tz;
        if (field == 3'b000) return old;
        tz = 0;
        while (!field[tz]) tz++;
        if (tz < SW_POSITIONS) return 2'(SW_POSITIONS - 1 - tz);
        return old;
    endfunction

    task automatic add_event(input t_kind kind, input logic [31:0] value);
        run_buf[run_len].kind  = kind;
        run_buf[run_len].value = value;
        run_buf[run_len].last  = 1'b0;
        run_len++;
    endtask

    task automatic derive_events(input logic [79:0] beat);
        logic [15:0] word;
        logic [31:0] enc;
        logic [31:0] now;
        logic [31:0] thresh;
        logic [31:0] delta;
        logic [31:0] held;
        logic [1:0]  sw0;
        logic [1:0]  sw1;
        int          i;
        word    = beat[15:0] & mask_q;
        enc     = beat[47:16];
        now     = beat[79:48];
        thresh  = (hold_q == 16'd0) ? 32'd1 : {16'd0, hold_q};
        run_len = 0;
        for (i = 0; i < 16; i++) begin
            if (word[i] != prev_word[i]) begin
                add_event(KIND_CHANGE, 32'(i));
                if (word[i]) begin
                    add_event(KIND_RISE, 32'(i));
                    rise_at[i] = now;
                    armed[i]   = 1'b1;
                end else begin
                    add_event(KIND_FALL, 32'(i));
                    armed[i] = 1'b0;
                end
            end
            held = now - rise_at[i];
            if (word[i] && armed[i] && held >= thresh) begin
                add_event(KIND_LONG, 32'(i));
                armed[i] = 1'b0;
            end
        end
        prev_word = word;

        sw0 = switch_decode(word[11:9], sw_pos[0]);
        sw1 = switch_decode(word[14:12], sw_pos[1]);
        if (sw0 != sw_pos[0]) add_event(KIND_SWITCH, 32'd0);
        if (sw1 != sw_pos[1]) add_event(KIND_SWITCH, 32'd1);
        sw_pos[0] = sw0;
        sw_pos[1] = sw1;

        delta    = enc - last_enc;
        last_enc = enc;
        if (delta != 32'd0) begin
            add_event(KIND_ENC_CHANGE, delta);
            add_event(delta[31] ? KIND_DECREASE : KIND_INCREASE, enc);
        end

        if (run_len > 0) run_buf[run_len-1].last = 1'b1;
        for (i = 0; i < run_len; i++) due_events.insert(due_events.size(), run_buf[i]);
    endtask

    task automatic compare_beat();
        t_event got;
        t_event want;
        got.kind  = t_kind'(i_m_tuser);
        got.value = i_m_tdata;
        got.last  = i_m_tlast;
        beats++;
        if (due_events.size() == 0) begin
            fails++;
            $display("%0t: exp no beat, got kind=%0d value=%h last=%b", $time,
                     got.kind, got.value, got.last);
        end else begin
            want = due_events.pop_front();
            if (got !== want) begin
                fails++;
                $display("%0t: exp kind=%0d value=%h last=%b got kind=%0d value=%h last=%b",
                         $time, want.kind, want.value, want.last,
                         got.kind, got.value, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mask_q    = 16'hFFFF;
            hold_q    = 16'd1000;
            prev_word = 16'h0000;
            armed     = 16'h0000;
            sw_pos[0] = 2'd0;
            sw_pos[1] = 2'd0;
            last_enc  = 32'd0;
            for (int k = 0; k < 16; k++) rise_at[k] = 32'd0;
            due_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INPUT_MASK: mask_q = i_cfg_data;
                    REG_HOLD_MS:    hold_q = i_cfg_data;
                    default: ;
                endcase
            end
            // an event beat always belongs to an earlier sample, so compare first
            if (i_m_tvalid && i_m_tready) compare_beat();
            if (i_s_tvalid && i_s_tready) derive_events(i_s_tdata);
        end
        o_pending    <= due_events.size();
        o_fail_count <= fails;
        o_beat_count <= beats;
    end

endmodule

/* dv/input_event_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_generator_tb: stimulus and verdict for the input event generator
// Directed samples hit full-word edges, long presses, hold time wrap, switch
// decode and encoder extremes; random phases then mix bit toggles, switch
// patterns, time steps and encoder moves over several config settings.
// ----------------------------------------------------------------------------
module input_event_generator_tb;
    import ieg_pkg::*;
    import ieg_dv_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = REG_INPUT_MASK;
    logic [15:0] i_cfg_data    = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = 80'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int beat_count;

    // stall bursts on both sides while set; cleared for the closing phase
    logic idle_en = 1'b1;
    int   rx_stall = 0;

    // running sample content for the random phases
    logic [15:0] raw_now   = 16'h0000;
    logic [31:0] enc_now   = 32'd0;
    logic [31:0] clock_ms  = 32'd0;
    int          n_samples = 0;
    int          n_settings = 0;

    input_event_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ieg_event_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beat_count (beat_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: tready drops for bursts counted down by rx_stall while idling is on
    always @(posedge i_clk) begin
        if (!idle_en) begin
            rx_stall      <= 0;
            m_axis_tready <= 1'b1;
        end else if (rx_stall != 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= (rx_stall == 1);
        end else if ($urandom_range(0, 4) == 0) begin
            rx_stall      <= $urandom_range(1, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One sample beat, optionally preceded by a gap. Returns at the edge
    // where the beat was taken; tvalid stays high for a following beat.
    task automatic send_sample(input logic [15:0] raw, input logic [31:0] enc,
                               input logic [31:0] tm);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tm, enc, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        n_samples++;
    endtask

    // Wait until every predicted beat has come out, then give a sample
    // with no events time to drain before touching the registers.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] mask, input logic [15:0] hold);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_INPUT_MASK;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        i_cfg_index <= REG_HOLD_MS;
        i_cfg_data  <= hold;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // Random samples: mostly small changes to the previous word so presses
    // last long enough to reach the hold time, plus noise and big jumps.
    task automatic run_phase(input logic [15:0] mask, input logic [15:0] hold,
                             input int count);
        int span;
        int k;
        settle();
        set_config(mask, hold);
        span = 2 * int'(hold) + 2;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: raw_now = 16'($urandom);
                1: raw_now = 16'h0000;
                2: raw_now = 16'hFFFF;
                3: raw_now = (raw_now & ~16'h7E00) |
                             (16'($urandom_range(0, 7)) << 9) |
                             (16'($urandom_range(0, 7)) << 12);
                4: ;
                default: begin
                    raw_now = raw_now ^ (16'h1 << $urandom_range(0, 15));
                    if ($urandom_range(0, 1) == 0)
                        raw_now = raw_now ^ (16'h1 << $urandom_range(0, 15));
                end
            endcase
            case ($urandom_range(0, 7))
                0: clock_ms = $urandom;
                1: ;
                2, 3: clock_ms = clock_ms + 32'($urandom_range(0, span));
                default: clock_ms = clock_ms + 32'($urandom_range(0, span / 4 + 1));
            endcase
            case ($urandom_range(0, 5))
                0: enc_now = $urandom;
                1, 2: ;
                default: enc_now = enc_now + 32'($urandom_range(0, 20)) - 32'd10;
            endcase
            send_sample(raw_now, enc_now, clock_ms);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- reset config: mask all ones, hold 1000 ms ---
        send_sample(16'h0000, 32'd0, 32'd0);            // nothing moves
        send_sample(16'hFFFF, 32'd1, 32'd5);            // every bit, both switches, encoder
        send_sample(16'hFFFF, 32'd1, 32'd1004);         // one ms short of long press
        send_sample(16'hFFFF, 32'd1, 32'd1005);         // long press on all bits
        send_sample(16'hFFFF, 32'd1, 32'd3000);         // already reported
        send_sample(16'h0000, 32'h8000_0000, 32'd3001); // all fall, big positive delta
        send_sample(16'h0000, 32'h7FFF_FFFF, 32'd3002); // delta of minus one
        // switch decode: one-hot and two-bit patterns on both fields
        send_sample(16'h0400, 32'h7FFF_FFFF, 32'd3003);
        send_sample(16'h0800, 32'h7FFF_FFFF, 32'd3004);
        send_sample(16'h6000, 32'h7FFF_FFFF, 32'd3005);
        send_sample(16'h1000, 32'h7FFF_FFFF, 32'd3006);
        send_sample(16'h0000, 32'h7FFF_FFFF, 32'd3007); // empty fields keep positions

        // --- partial mask, zero hold time (behaves as one ms) ---
        settle();
        set_config(16'h00F0, 16'd0);
        send_sample(16'hFFFF, 32'h7FFF_FFFF, 32'd10);
        send_sample(16'hFFFF, 32'h7FFF_FFFF, 32'd10);   // no long in the rise ms
        send_sample(16'hFFFF, 32'h7FFF_FFFF, 32'd11);
        send_sample(16'h0010, 32'h7FFF_FFFF, 32'd12);

        // --- longest hold, elapsed time wraps across zero ---
        settle();
        set_config(16'hFFFF, 16'hFFFF);
        send_sample(16'h0001, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
        send_sample(16'h0001, 32'h7FFF_FFFF, 32'h0000_FFEE);
        send_sample(16'h0001, 32'h7FFF_FFFF, 32'h0000_FFEF);
        send_sample(16'h0000, 32'h7FFF_FFFF, 32'h0001_0000);
        send_sample(16'h0001, 32'h7FFF_FFFF, 32'h0001_0001);
        send_sample(16'h0000, 32'h7FFF_FFFF, 32'h0001_0002); // fall disarms
        send_sample(16'h0001, 32'h7FFF_FFFF, 32'h0001_0003);
        send_sample(16'h0001, 32'h0000_0000, 32'h0002_2000);

        raw_now  = 16'h0001;
        enc_now  = 32'd0;
        clock_ms = 32'h0002_2000;

        run_phase(16'hFFFF, 16'd1, 50);
        run_phase(16'($urandom), 16'($urandom_range(2, 300)), 60);
        run_phase(16'h0000, 16'hFFFF, 25);
        run_phase(16'hFFFF, 16'hFFFF, 40);
        run_phase(16'($urandom) | 16'h7E00, 16'd0, 45);
        // closing phase runs at full rate on both sides
        settle();
        idle_en <= 1'b0;
        run_phase(16'hFFFF, 16'($urandom_range(1, 50)), 50);
        settle();

        $display("covered %0d samples and %0d event beats over %0d register settings",
                 n_samples, beat_count, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
